@@ src/mcr_pkg.sv @@
package mcr_pkg;

  // Fixed field widths.
  localparam int CENTER_BITS = 15;
  localparam int COLOR_BITS  = 24;

  // Defaults for the top-level parameters.
  localparam int COORD_BITS_DEF  = 16;
  localparam int RADIUS_BITS_DEF = 13;

  // The decision variable carries this many bits beyond the radius.
  localparam int DEC_EXTRA_BITS = 7;

  // Input item function codes.
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  // Decision variable constants: d0 = 3 - 2r, then +10 on a diagonal move, +6 otherwise.
  localparam int D_INIT = 3;
  localparam int K_DIAG = 10;
  localparam int K_SIDE = 6;

  // Pixel index of the eighth pixel of a run.
  localparam logic [2:0] PIX_LAST = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_STEP_XY,
    ST_STEP_T,
    ST_STEP_D,
    ST_EMIT
  } state_t;

  typedef struct packed {
    state_t     state;
    logic [2:0] pix;
    logic       last;
  } seq_t;

endpackage

@@ src/mcr_alu.sv @@
module mcr_alu import mcr_pkg::*; #(
  parameter int W = 32
) (
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  input  logic         inv,
  input  logic         cin,
  output logic [W-1:0] sum
);

  logic [W-1:0] b_eff;

  // With inv and cin both set this is a - b.
  assign b_eff = inv ? ~b : b;
  assign sum   = a + b_eff + {{(W-1){1'b0}}, cin};

endmodule

@@ src/mcr_ctrl.sv @@
module mcr_ctrl import mcr_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic accept,
  input  logic func,
  input  logic active,
  output logic busy,
  output seq_t seq
);

  state_t     state_r, state_nxt;
  logic [2:0] pix_r, pix_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pix_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pix_r   <= pix_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (func == FUNC_START) begin
            state_nxt = ST_LOAD;
          end else if (active) begin
            state_nxt = ST_STEP_XY;
          end
        end
      end
      ST_LOAD:    state_nxt = ST_EMIT;
      ST_STEP_XY: state_nxt = ST_STEP_T;
      ST_STEP_T:  state_nxt = ST_STEP_D;
      ST_STEP_D:  state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (pix_r == PIX_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    pix_nxt   = (state_r == ST_EMIT) ? pix_r + 3'd1 : '0;
    busy      = (state_r != ST_IDLE);
    seq.state = state_r;
    seq.pix   = pix_r;
    seq.last  = (pix_r == PIX_LAST);
  end

endmodule

@@ src/midpoint_circle_rasterizer.sv @@
// Midpoint circle rasterizer. Pulse start with in_func low to begin a circle: the block loads
// the center, radius and color and emits the eight symmetric pixels of the top point. Each start
// with in_func high then runs one step of the midpoint loop and emits eight more pixels.
// Results appear one beat per cycle, each marked by out_valid for exactly one cycle, and the
// receiver cannot hold them off, so it must take every beat as it comes. After a start is
// accepted busy stays high while the block forms the initial decision value and then emits the
// eight pixels; the next item can be taken once busy is low again. After an advance busy stays
// high while the block steps x, y and the decision value and then emits eight pixels, and the
// next item can again be taken once busy is low. An advance with no circle in progress leaves
// busy low and emits nothing, so the next item can be taken at the following edge. Start is
// ignored while busy is high. A single pair of adder lanes does all the datapath arithmetic: it
// forms one pixel per cycle and one part of the loop update per cycle. Each pixel beat is
// registered before it leaves the block. The eighth pixel of each run
// carries out_last_of_run, and the eighth pixel of the step after which y drops below x also
// carries out_circle_done; after that, advances emit nothing until the next circle starts.
// Pixel coordinates wrap at COORD_BITS.
module midpoint_circle_rasterizer import mcr_pkg::*; #(
  parameter int COORD_BITS  = COORD_BITS_DEF,
  parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic signed [CENTER_BITS-1:0] in_center_x,
  input  logic signed [CENTER_BITS-1:0] in_center_y,
  input  logic [RADIUS_BITS-1:0]        in_radius,
  input  logic [COLOR_BITS-1:0]         in_color,
  output logic                          out_valid,
  output logic signed [COORD_BITS-1:0]  out_pixel_x,
  output logic signed [COORD_BITS-1:0]  out_pixel_y,
  output logic [COLOR_BITS-1:0]         out_pixel_color,
  output logic                          out_last_of_run,
  output logic                          out_circle_done
);

  // Offsets are signed and one bit wider than the radius, since y can go to -1.
  localparam int OFF_BITS = RADIUS_BITS + 1;
  localparam int DEC_BITS = RADIUS_BITS + DEC_EXTRA_BITS;
  localparam int MAX_A    = (COORD_BITS > DEC_BITS) ? COORD_BITS : DEC_BITS;
  localparam int MAX_B    = (MAX_A > CENTER_BITS) ? MAX_A : CENTER_BITS;
  // Lane width: one guard bit over every operand so that sign extension always has room.
  localparam int UW       = MAX_B + 1;

  logic accept;
  seq_t seq;

  // Circle state.
  logic signed [CENTER_BITS-1:0] cx_r, cy_r;
  logic [COLOR_BITS-1:0]         color_r;
  logic [OFF_BITS-1:0]           x_r, y_r;
  logic [DEC_BITS-1:0]           d_r;
  logic [UW-1:0]                 t_r;
  logic                          dpos_r;
  logic                          done_r;
  logic                          active_r;

  // Output beat registers.
  logic                  out_valid_r;
  logic [COORD_BITS-1:0] px_r, py_r;
  logic [COLOR_BITS-1:0] pcolor_r;
  logic                  plast_r, pdone_r;

  // Shared adder lanes.
  logic [UW-1:0] l0_a, l0_b, l0_sum;
  logic [UW-1:0] l1_a, l1_b, l1_sum;
  logic          l0_inv, l0_cin, l1_inv, l1_cin;

  // Sign-extended views of the state.
  logic [UW-1:0] x_ext, y_ext, d_ext, cx_ext, cy_ext;
  logic          dpos;

  assign accept = start && !busy;

  mcr_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .func   (in_func),
    .active (active_r),
    .busy   (busy),
    .seq    (seq)
  );

  assign x_ext  = {{(UW-OFF_BITS){x_r[OFF_BITS-1]}}, x_r};
  assign y_ext  = {{(UW-OFF_BITS){y_r[OFF_BITS-1]}}, y_r};
  assign d_ext  = {{(UW-DEC_BITS){d_r[DEC_BITS-1]}}, d_r};
  assign cx_ext = {{(UW-CENTER_BITS){cx_r[CENTER_BITS-1]}}, cx_r};
  assign cy_ext = {{(UW-CENTER_BITS){cy_r[CENTER_BITS-1]}}, cy_r};

  // The decision value is strictly positive: sign clear and not zero.
  assign dpos = !d_r[DEC_BITS-1] && (d_r != '0);

  // Operand selection for the two lanes, one setting per sequencer state.
  always_comb begin
    l0_a   = '0;
    l0_b   = '0;
    l0_inv = 1'b0;
    l0_cin = 1'b0;
    l1_a   = '0;
    l1_b   = '0;
    l1_inv = 1'b0;
    l1_cin = 1'b0;
    case (seq.state)
      ST_LOAD: begin
        // d = 3 - 2r.
        l0_a   = UW'(D_INIT);
        l0_b   = {{(UW-OFF_BITS){1'b0}}, y_r[OFF_BITS-2:0], 1'b0};
        l0_inv = 1'b1;
        l0_cin = 1'b1;
      end
      ST_STEP_XY: begin
        // x + 1, and y - 1 when the decision value is positive.
        l0_a   = x_ext;
        l0_cin = 1'b1;
        l1_a   = y_ext;
        l1_inv = dpos;
      end
      ST_STEP_T: begin
        // t = x - y on a diagonal move, else x; meanwhile d + 10 or d + 6.
        l0_a   = x_ext;
        l0_b   = dpos_r ? y_ext : '0;
        l0_inv = dpos_r;
        l0_cin = dpos_r;
        l1_a   = d_ext;
        l1_b   = dpos_r ? UW'(K_DIAG) : UW'(K_SIDE);
      end
      ST_STEP_D: begin
        // d + 4t, and y - x whose sign tells that the loop has ended.
        l0_a   = d_ext;
        l0_b   = {t_r[UW-3:0], 2'b00};
        l1_a   = y_ext;
        l1_b   = x_ext;
        l1_inv = 1'b1;
        l1_cin = 1'b1;
      end
      ST_EMIT: begin
        // Bit 2 of the pixel index swaps x and y, bit 0 negates the column
        // offset and bit 1 negates the row offset.
        l0_a   = cx_ext;
        l0_b   = seq.pix[2] ? y_ext : x_ext;
        l0_inv = seq.pix[0];
        l0_cin = seq.pix[0];
        l1_a   = cy_ext;
        l1_b   = seq.pix[2] ? x_ext : y_ext;
        l1_inv = seq.pix[1];
        l1_cin = seq.pix[1];
      end
      default: begin
        l0_a = '0;
      end
    endcase
  end

  mcr_alu #(.W(UW)) u_lane0 (
    .a   (l0_a),
    .b   (l0_b),
    .inv (l0_inv),
    .cin (l0_cin),
    .sum (l0_sum)
  );

  mcr_alu #(.W(UW)) u_lane1 (
    .a   (l1_a),
    .b   (l1_b),
    .inv (l1_inv),
    .cin (l1_cin),
    .sum (l1_sum)
  );

  // The active flag is control state and is cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (accept && (in_func == FUNC_START)) begin
      active_r <= 1'b1;
    end else if (seq.state == ST_STEP_D) begin
      active_r <= !l1_sum[UW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_func == FUNC_START)) begin
      cx_r    <= in_center_x;
      cy_r    <= in_center_y;
      color_r <= in_color;
      x_r     <= '0;
      y_r     <= {1'b0, in_radius};
      done_r  <= 1'b0;
    end
    case (seq.state)
      ST_LOAD: begin
        d_r <= l0_sum[DEC_BITS-1:0];
      end
      ST_STEP_XY: begin
        x_r    <= l0_sum[OFF_BITS-1:0];
        y_r    <= l1_sum[OFF_BITS-1:0];
        dpos_r <= dpos;
      end
      ST_STEP_T: begin
        t_r <= l0_sum;
        d_r <= l1_sum[DEC_BITS-1:0];
      end
      ST_STEP_D: begin
        d_r    <= l0_sum[DEC_BITS-1:0];
        done_r <= l1_sum[UW-1];
      end
      default: begin
      end
    endcase
  end

  // One pixel beat per emit cycle, presented for exactly the following cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (seq.state == ST_EMIT);
    end
  end

  always_ff @(posedge clk) begin
    if (seq.state == ST_EMIT) begin
      px_r     <= l0_sum[COORD_BITS-1:0];
      py_r     <= l1_sum[COORD_BITS-1:0];
      pcolor_r <= color_r;
      plast_r  <= seq.last;
      pdone_r  <= seq.last && done_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = px_r;
  assign out_pixel_y     = py_r;
  assign out_pixel_color = pcolor_r;
  assign out_last_of_run = plast_r;
  assign out_circle_done = pdone_r;

endmodule

@@ dv/circle_pixel_checker.sv @@
`timescale 1ns / 1ps

// Watches both sides of the rasterizer, predicts the pixel beats of every accepted
// item and compares them in order against what the block emits.
module circle_pixel_checker import mcr_pkg::*; (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic                              in_func,
  input  logic signed [CENTER_BITS-1:0]     in_center_x,
  input  logic signed [CENTER_BITS-1:0]     in_center_y,
  input  logic [RADIUS_BITS_DEF-1:0]        in_radius,
  input  logic [COLOR_BITS-1:0]             in_color,
  input  logic                              out_valid,
  input  logic signed [COORD_BITS_DEF-1:0]  out_pixel_x,
  input  logic signed [COORD_BITS_DEF-1:0]  out_pixel_y,
  input  logic [COLOR_BITS-1:0]             out_pixel_color,
  input  logic                              out_last_of_run,
  input  logic                              out_circle_done,
  output int                                errors,
  output int                                outstanding,
  output int                                beats_checked,
  output int                                circles_closed
);

  localparam int OFS_W = RADIUS_BITS_DEF + 1;
  localparam int DEC_W = RADIUS_BITS_DEF + DEC_EXTRA_BITS;

  typedef struct packed {
    logic [COORD_BITS_DEF-1:0] px;
    logic [COORD_BITS_DEF-1:0] py;
    logic [COLOR_BITS-1:0]     color;
    logic                      last_of_run;
    logic                      circle_done;
  } pixel_t;

  pixel_t pixel_q[$];

  logic signed [CENTER_BITS-1:0] ctr_x, ctr_y;
  logic [COLOR_BITS-1:0]         ink;
  logic signed [OFS_W-1:0]       ofs_x, ofs_y;
  logic signed [DEC_W-1:0]       dec;
  logic                          running;

  // Queue the eight mirrored pixels of the current offsets. Odd slots negate the
  // column term, slots 2, 3, 6 and 7 negate the row term, and the upper half swaps x and y.
  function automatic void queue_octants(bit done);
    int     k, a, b, pxv, pyv;
    pixel_t pix;
    for (k = 0; k < 8; k++) begin
      a   = (k < 4) ? int'(ofs_x) : int'(ofs_y);
      b   = (k < 4) ? int'(ofs_y) : int'(ofs_x);
      pxv = (k % 2 == 1) ? int'(ctr_x) - a : int'(ctr_x) + a;
      pyv = ((k / 2) % 2 == 1) ? int'(ctr_y) - b : int'(ctr_y) + b;
      pix.px          = pxv[COORD_BITS_DEF-1:0];
      pix.py          = pyv[COORD_BITS_DEF-1:0];
      pix.color       = ink;
      pix.last_of_run = (k == 7);
      pix.circle_done = (k == 7) && done;
      pixel_q.push_back(pix);
    end
  endfunction

  function automatic void step_circle(logic f, logic signed [CENTER_BITS-1:0] cx,
                                      logic signed [CENTER_BITS-1:0] cy,
                                      logic [RADIUS_BITS_DEF-1:0] r,
                                      logic [COLOR_BITS-1:0] col);
    int                      nd;
    logic signed [OFS_W-1:0] sx, sy;
    if (f == FUNC_START) begin
      ctr_x   = cx;
      ctr_y   = cy;
      ink     = col;
      ofs_x   = '0;
      ofs_y   = {1'b0, r};
      nd      = D_INIT - 2 * int'(r);
      dec     = nd[DEC_W-1:0];
      running = 1'b1;
      queue_octants(1'b0);
    end else if (running) begin
      sx = ofs_x + OFS_W'(1);
      sy = ofs_y;
      nd = int'(dec);
      if (dec > 0) begin
        sy = ofs_y - OFS_W'(1);
        nd = nd + 4 * (int'(sx) - int'(sy)) + K_DIAG;
      end else begin
        nd = nd + 4 * int'(sx) + K_SIDE;
      end
      ofs_x = sx;
      ofs_y = sy;
      dec   = nd[DEC_W-1:0];
      if (sy < sx) running = 1'b0;
      queue_octants(sy < sx);
    end
  endfunction

  function automatic void check_field(string name, logic signed [31:0] want,
                                      logic signed [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    pixel_t want;
    if (!rst_n) begin
      ctr_x   = '0;
      ctr_y   = '0;
      ink     = '0;
      ofs_x   = '0;
      ofs_y   = '0;
      dec     = '0;
      running = 1'b0;
      pixel_q.delete();
    end else begin
      if (out_valid) begin
        if (pixel_q.size() == 0) begin
          $error("pixel beat with nothing expected: x %0d, y %0d", out_pixel_x, out_pixel_y);
          errors++;
        end else begin
          want = pixel_q.pop_front();
          check_field("pixel_x", 32'($signed(want.px)), 32'(out_pixel_x));
          check_field("pixel_y", 32'($signed(want.py)), 32'(out_pixel_y));
          check_field("pixel_color", 32'(want.color), 32'(out_pixel_color));
          check_field("last_of_run", 32'(want.last_of_run), 32'(out_last_of_run));
          check_field("circle_done", 32'(want.circle_done), 32'(out_circle_done));
          beats_checked++;
          if (want.circle_done) circles_closed++;
        end
      end
      if (start && !busy) begin
        step_circle(in_func, in_center_x, in_center_y, in_radius, in_color);
      end
    end
    outstanding <= pixel_q.size();
  end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

// Top of the rasterizer bench. It only makes stimulus and gives the verdict; the
// checker beside the block predicts every pixel beat and counts mismatches.
module testbench;
  import mcr_pkg::*;

  // Worst correct run is a few hundred items plus sender gaps bounded by MAX_GAP per item,
  // so this limit is many times the slowest pass.
  localparam int CYCLE_LIMIT = 200000;
  localparam int MAX_GAP     = 40;
  localparam int TAIL_CYCLES = 16;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              start = 1'b0;
  logic                              busy;
  logic                              in_func = FUNC_START;
  logic signed [CENTER_BITS-1:0]     in_center_x = '0;
  logic signed [CENTER_BITS-1:0]     in_center_y = '0;
  logic [RADIUS_BITS_DEF-1:0]        in_radius = '0;
  logic [COLOR_BITS-1:0]             in_color = '0;
  logic                              out_valid;
  logic signed [COORD_BITS_DEF-1:0]  out_pixel_x;
  logic signed [COORD_BITS_DEF-1:0]  out_pixel_y;
  logic [COLOR_BITS-1:0]             out_pixel_color;
  logic                              out_last_of_run;
  logic                              out_circle_done;

  int errors, outstanding, beats_checked, circles_closed;
  int cycles = 0;
  int items_sent = 0;
  int starts_sent = 0;
  int idle_pct = 0;

  midpoint_circle_rasterizer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_radius       (in_radius),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_of_run (out_last_of_run),
    .out_circle_done (out_circle_done)
  );

  circle_pixel_checker u_pixel_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_func         (in_func),
    .in_center_x     (in_center_x),
    .in_center_y     (in_center_y),
    .in_radius       (in_radius),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_color (out_pixel_color),
    .out_last_of_run (out_last_of_run),
    .out_circle_done (out_circle_done),
    .errors          (errors),
    .outstanding     (outstanding),
    .beats_checked   (beats_checked),
    .circles_closed  (circles_closed)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Watchdog: a hung handshake or a lost pixel beat ends the run here.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Present one item and hold it until the block takes it. Before presenting, the
  // sender may idle for a random stretch; the fields carry junk then, which the block
  // must ignore because start is low. We return at the edge that accepted the beat,
  // so the next call drives start exactly once in that time step.
  task automatic send(input logic f, input logic [CENTER_BITS-1:0] cx,
                      input logic [CENTER_BITS-1:0] cy,
                      input logic [RADIUS_BITS_DEF-1:0] r,
                      input logic [COLOR_BITS-1:0] col);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(0, 99) < idle_pct) begin
      start       <= 1'b0;
      in_func     <= 1'($urandom);
      in_center_x <= CENTER_BITS'($urandom);
      in_radius   <= RADIUS_BITS_DEF'($urandom);
      @(posedge clk);
      gap++;
    end
    start       <= 1'b1;
    in_func     <= f;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius   <= r;
    in_color    <= col;
    do @(posedge clk); while (busy);
    items_sent++;
    if (f == FUNC_START) starts_sent++;
  endtask

  // Advance beats ignore the center, radius and color, so those carry random junk.
  task automatic advance();
    send(FUNC_ADVANCE, CENTER_BITS'($urandom), CENTER_BITS'($urandom),
         RADIUS_BITS_DEF'($urandom), COLOR_BITS'($urandom));
  endtask

  task automatic circle(input logic [RADIUS_BITS_DEF-1:0] r, input int n_adv);
    send(FUNC_START, CENTER_BITS'($urandom), CENTER_BITS'($urandom), r,
         COLOR_BITS'($urandom));
    repeat (n_adv) advance();
  endtask

  // Drop start and wait until the block is idle and every predicted beat has been seen.
  // The first edge lets the checker's count catch up with the last accepted beat.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
  endtask

  // Random phase. Most of it is whole circles of small radius, driven with enough
  // advances to run past the finishing step, so the tail advances also hit the idle
  // case. Some circles are cut short by the next start, a few use a random full-width
  // radius for a handful of steps, and the rest are lone advances.
  task automatic random_phase(input int pct, input int target);
    int first, sel, n;
    logic [RADIUS_BITS_DEF-1:0] r;
    idle_pct = pct;
    first = items_sent;
    while (items_sent - first < target) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        advance();
      end else if (sel < 16) begin
        r = RADIUS_BITS_DEF'($urandom_range(0, (1 << RADIUS_BITS_DEF) - 1));
        circle(r, $urandom_range(0, 6));
      end else begin
        r = RADIUS_BITS_DEF'($urandom_range(0, 24));
        if ($urandom_range(0, 7) == 0) n = $urandom_range(0, r / 2);
        else n = r * 3 / 4 + 2;
        circle(r, n);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. The sender idles as in the first random phase.
    idle_pct = 26;
    // An advance straight after reset has no circle to step and must emit nothing.
    advance();
    // Radius zero at the most negative column and the top row: eight copies of the
    // center, then one advance that finishes at once, then an advance into idle.
    send(FUNC_START, 15'h4000, 15'h3FFF, '0, 24'hFFFFFF);
    advance();
    advance();
    // Largest radius at the opposite corner with a black color, stepped twice.
    send(FUNC_START, 15'h3FFF, 15'h4000, 13'h1FFF, 24'h000000);
    advance();
    advance();
    // A new start while that circle is still running must replace it.
    send(FUNC_START, 15'h0000, 15'h0000, 13'd1, 24'hA5A5A5);
    advance();
    advance();
    // Small complete circles; the extra advances land after the finishing step.
    send(FUNC_START, 15'd100, -15'sd100, 13'd5, 24'h123456);
    repeat (6) advance();
    send(FUNC_START, -15'sd7, 15'd9, 13'd2, 24'h5A5A5A);
    repeat (4) advance();

    // Let everything drain before the random part, then hold off a little longer.
    drain();
    repeat ($urandom_range(2, 9)) @(posedge clk);

    random_phase(26, 90);
    random_phase(88, 90);
    random_phase(0, 80);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d items (%0d circle starts) and checked %0d pixel beats.",
             items_sent, starts_sent, beats_checked);
    $display("%0d circles ran to completion under sender idling of 26, 88 and 0 percent.",
             circles_closed);
    if (errors == 0 && outstanding == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
